/* sv/fuzzy_tnorm_tconorm_reducer_unit_macros.svh */
// assertion macros for the fuzzy t-norm / t-conorm reducer checker
`ifndef FUZZY_TNORM_TCONORM_REDUCER_UNIT_MACROS_SVH
`define FUZZY_TNORM_TCONORM_REDUCER_UNIT_MACROS_SVH

// same-cycle implication
`define FTR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ftr check failed");

// next-cycle implication
`define FTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ftr check failed");

`endif

/* sv/ftr_pkg.sv */
// shared types and constants for the fuzzy t-norm / t-conorm reducer
package ftr_pkg;

   localparam int DEG_W      = 18;
   localparam int MODE_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [0:0] CSR_IDX_MODE = 1'b0;

   typedef enum logic [MODE_W-1:0] {
      MODE_MIN          = 3'd0,
      MODE_LUKAS_TNORM  = 3'd1,
      MODE_PRODUCT      = 3'd2,
      MODE_MAX          = 3'd3,
      MODE_LUKAS_TCONORM = 3'd4,
      MODE_PROB_SUM     = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_MISSING = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   typedef struct packed {
      mode_type mode;
      logic     restart;
   } cfg_type;

endpackage

/* sv/ftr_csr.sv */
// configuration register block with the operation mode register
module ftr_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ftr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ftr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ftr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready,
   output ftr_pkg::cfg_type                   cfg
);

   ftr_pkg::mode_type mode_ff;
   ftr_pkg::mode_type mode_in;
   logic              wr_mode;
   logic [0:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[ftr_pkg::CSR_ADDR_W-1 -: 1];

   always_comb begin
      wr_mode    = 1'b0;
      csr_prdata = '0;
      unique case (reg_idx)
         ftr_pkg::CSR_IDX_MODE: begin
            wr_mode    = csr_psel && csr_penable && csr_pwrite && csr_pready;
            csr_prdata = ftr_pkg::CSR_DATA_W'(mode_ff);
         end
         default: begin
            wr_mode    = 1'b0;
            csr_prdata = '0;
         end
      endcase
   end

   assign mode_in = wr_mode ? ftr_pkg::mode_type'(csr_pwdata[ftr_pkg::MODE_W-1:0]) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ftr_pkg::MODE_MIN;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign cfg.mode    = mode_in;
   assign cfg.restart = wr_mode;

endmodule

/* sv/ftr_fold.sv */
// one fold step: status check and the selected t-norm or t-conorm
module ftr_fold #(
   parameter int FRAC_BITS = 16
) (
   input  ftr_pkg::mode_type                 mode,
   input  logic [FRAC_BITS:0]                acc_i,
   input  ftr_pkg::status_type               status_i,
   input  logic signed [ftr_pkg::DEG_W-1:0]  degree,
   input  logic                              missing,
   output logic [FRAC_BITS:0]                acc_o,
   output ftr_pkg::status_type               status_o
);

   localparam int AccW = FRAC_BITS + 1;
   localparam int MagW = ftr_pkg::DEG_W - 1;
   localparam int CmpW = (MagW > AccW) ? MagW : AccW;
   localparam logic [CmpW-1:0] OneWide = CmpW'(1) << FRAC_BITS;
   localparam logic [AccW-1:0] OneAcc  = AccW'(1) << FRAC_BITS;
   localparam logic [AccW:0]   OneSum  = (AccW + 1)'(1) << FRAC_BITS;

   logic                 negative;
   logic [CmpW-1:0]      mag_w;
   logic [AccW-1:0]      v;
   logic [2*AccW-1:0]    prod_full;
   logic [AccW-1:0]      prod;
   logic [AccW:0]        sum;
   logic [AccW:0]        lukas_diff;
   logic [AccW:0]        prob_sum;
   logic [AccW-1:0]      folded;

   assign negative   = degree[ftr_pkg::DEG_W-1];
   assign mag_w      = CmpW'(degree[MagW-1:0]);
   assign v          = mag_w[AccW-1:0];
   assign prod_full  = {{AccW{1'b0}}, acc_i} * {{AccW{1'b0}}, v};
   assign prod       = prod_full[FRAC_BITS +: AccW];
   assign sum        = {1'b0, acc_i} + {1'b0, v};
   assign lukas_diff = sum - OneSum;
   assign prob_sum   = sum - {1'b0, prod};

   always_comb begin
      case (mode)
         ftr_pkg::MODE_MIN:           folded = (v < acc_i) ? v : acc_i;
         ftr_pkg::MODE_LUKAS_TNORM:   folded = (sum > OneSum) ? lukas_diff[AccW-1:0] : '0;
         ftr_pkg::MODE_PRODUCT:       folded = prod;
         ftr_pkg::MODE_MAX:           folded = (v > acc_i) ? v : acc_i;
         ftr_pkg::MODE_LUKAS_TCONORM: folded = (sum > OneSum) ? OneAcc : sum[AccW-1:0];
         ftr_pkg::MODE_PROB_SUM:      folded = prob_sum[AccW-1:0];
         default:                     folded = acc_i;
      endcase
   end

   always_comb begin
      acc_o    = acc_i;
      status_o = status_i;
      if (status_i == ftr_pkg::STATUS_OK) begin
         if (missing) begin
            status_o = ftr_pkg::STATUS_MISSING;
         end else if (negative || (mag_w > OneWide)) begin
            status_o = ftr_pkg::STATUS_RANGE;
         end else begin
            acc_o = folded;
         end
      end
   end

endmodule

/* sv/fuzzy_tnorm_tconorm_reducer_unit.sv */
// top level of the fuzzy t-norm / t-conorm run reducer
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | degree, is_missing, last_element
//   rsp     | out       | rsp_valid/stall   | reduced_degree, run_status
//   csr     | in/out    | apb psel/penable  | operation_mode at byte 0
//
// one beat per cycle unless a last beat waits: the fold is one compare, add or
// 17x17 multiply between the input register and the accumulator register
// a run's result is registered as its last beat leaves the input register
// reset is synchronous; it clears mode to min, status to ok, acc to 1.0
// rsp_stall only holds back a last beat while an unread result is pending
module fuzzy_tnorm_tconorm_reducer_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [ftr_pkg::DEG_W-1:0]   req_degree,
   input  logic                               req_is_missing,
   input  logic                               req_last_element,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [FRAC_BITS:0]                 rsp_reduced_degree,
   output logic [ftr_pkg::STATUS_W-1:0]       rsp_run_status,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ftr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ftr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ftr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int AccW = FRAC_BITS + 1;
   localparam logic [AccW-1:0] OneAcc = AccW'(1) << FRAC_BITS;

   ftr_pkg::cfg_type cfg;

   logic                              s1_valid_ff, s1_valid_in;
   logic signed [ftr_pkg::DEG_W-1:0]  s1_degree_ff;
   logic                              s1_missing_ff;
   logic                              s1_last_ff;
   logic [AccW-1:0]                   acc_ff, acc_in;
   ftr_pkg::status_type               status_ff, status_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [AccW-1:0]                   rsp_degree_ff, rsp_degree_in;
   ftr_pkg::status_type               rsp_status_ff, rsp_status_in;

   logic                              req_take;
   logic                              s1_adv;
   logic                              emit;
   logic [AccW-1:0]                   acc_next;
   ftr_pkg::status_type               status_next;
   logic [AccW-1:0]                   identity;

   ftr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ftr_fold #(
      .FRAC_BITS (FRAC_BITS)
   ) u_fold (
      .mode     (cfg.mode),
      .acc_i    (acc_ff),
      .status_i (status_ff),
      .degree   (s1_degree_ff),
      .missing  (s1_missing_ff),
      .acc_o    (acc_next),
      .status_o (status_next)
   );

   // a last beat waits while an unread result sits in the output register
   assign s1_adv    = s1_valid_ff && !(s1_last_ff && rsp_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;
   assign emit      = s1_adv && s1_last_ff;

   assign identity = (cfg.mode <= ftr_pkg::MODE_PRODUCT) ? OneAcc : '0;

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      acc_in    = acc_ff;
      status_in = status_ff;
      if (cfg.restart || emit) begin
         acc_in    = identity;
         status_in = ftr_pkg::STATUS_OK;
      end else if (s1_adv) begin
         acc_in    = acc_next;
         status_in = status_next;
      end
   end

   always_comb begin
      rsp_degree_in = rsp_degree_ff;
      rsp_status_in = rsp_status_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_degree_in = (status_next == ftr_pkg::STATUS_OK) ? acc_next : '0;
         rsp_status_in = status_next;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         acc_ff       <= OneAcc;
         status_ff    <= ftr_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         acc_ff       <= acc_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_degree_ff  <= req_degree;
         s1_missing_ff <= req_is_missing;
         s1_last_ff    <= req_last_element;
      end
      rsp_degree_ff <= rsp_degree_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reduced_degree = rsp_degree_ff;
   assign rsp_run_status     = rsp_status_ff;

endmodule

/* sv/ftr_checker.sv */
// port-level checker for the reducer, bound to the top level
`include "fuzzy_tnorm_tconorm_reducer_unit_macros.svh"

module ftr_checker #(
   parameter int FRAC_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [FRAC_BITS:0]            rsp_reduced_degree,
   input logic [ftr_pkg::STATUS_W-1:0]  rsp_run_status
);

   localparam logic [FRAC_BITS:0] OneAcc = (FRAC_BITS + 1)'(1) << FRAC_BITS;

   // stalled result beat holds
   `FTR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_reduced_degree) && $stable(rsp_run_status))

   `FTR_ASSERT_NOW(a_status_code, clock, reset, rsp_valid, rsp_run_status == ftr_pkg::STATUS_OK || rsp_run_status == ftr_pkg::STATUS_MISSING || rsp_run_status == ftr_pkg::STATUS_RANGE)

   // failed runs report a zero degree
   `FTR_ASSERT_NOW(a_err_zero, clock, reset, rsp_valid && rsp_run_status != ftr_pkg::STATUS_OK, rsp_reduced_degree == '0)

   `FTR_ASSERT_NOW(a_degree_range, clock, reset, rsp_valid, rsp_reduced_degree <= OneAcc)

endmodule

bind fuzzy_tnorm_tconorm_reducer_unit ftr_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_ftr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_reduced_degree (rsp_reduced_degree),
   .rsp_run_status     (rsp_run_status)
);
